### rtl/core/dfm_pkg.sv
// Shared types and constants for the Dinic maximum flow unit.
// Depends on nothing; every other file of the block imports it.
package dfm_pkg;

	// Fixed widths of the edge and result words.
	localparam int unsigned NODE_FIELD_BITS = 11;
	localparam int unsigned CAP_FIELD_BITS  = 30;
	localparam int unsigned FLOW_BITS       = 40;

	// Flow offered at the root of each blocking-flow search.
	localparam logic [29:0] ROOT_LIMIT  = 30'd1000000412;
	localparam int unsigned SOURCE_NODE = 1;

	// Register index decoded from paddr[2].
	localparam logic REG_NODE_COUNT = 1'b0;

	// Datapath operations, one per controller step.
	typedef enum logic [4:0] {
		OP_CLEAR, OP_IDLE, OP_L_RDA, OP_L_WRA, OP_L_WRB, OP_L_END,
		OP_B_CLR, OP_B_INIT, OP_B_POP, OP_B_U, OP_B_U2, OP_B_ARC, OP_B_V, OP_B_CHK,
		OP_B_DONE, OP_B_DONE2,
		OP_D_INIT, OP_D_LD, OP_D_TOP, OP_D_ARC, OP_D_V, OP_D_CHK, OP_D_POP,
		OP_D_POPR, OP_D_UPD1, OP_D_UPD2, OP_D_NXT, OP_FINISH
	} op_t;

	// Controller states.
	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_L_RDA, ST_L_WRA, ST_L_WRB, ST_L_END,
		ST_B_CLR, ST_B_INIT, ST_B_POP, ST_B_U, ST_B_U2, ST_B_ARC, ST_B_V, ST_B_CHK,
		ST_B_DONE, ST_B_DONE2,
		ST_D_INIT, ST_D_LD, ST_D_TOP, ST_D_ARC, ST_D_V, ST_D_CHK, ST_D_POP,
		ST_D_POPR, ST_D_UPD1, ST_D_UPD2, ST_D_NXT, ST_FINISH
	} state_t;

	// Command from controller to datapath.
	typedef struct packed {
		op_t  op;
		logic take;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic clr_last;
		logic edge_ok;
		logic edge_last;
		logic q_empty;
		logic k_nil;
		logic bfs_take;
		logic lvl_zero;
		logic at_sink;
		logic push_ok;
		logic sp_zero;
		logic flow_zero;
		logic out_free;
	} status_t;

endpackage

### rtl/core/dfm_edge_if.sv
// Edge word channel of the Dinic maximum flow unit.
// Depends on dfm_pkg for the field widths.
interface dfm_edge_if;
	import dfm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [NODE_FIELD_BITS-1:0] end_a;
	logic [NODE_FIELD_BITS-1:0] end_b;
	logic [CAP_FIELD_BITS-1:0]  capacity;
	logic                       last_edge;

	modport source (output valid, end_a, end_b, capacity, last_edge, input ready);
	modport sink (input valid, end_a, end_b, capacity, last_edge, output ready);
endinterface

### rtl/core/dfm_result_if.sv
// Result word channel of the Dinic maximum flow unit.
// Depends on dfm_pkg for the field widths.
interface dfm_result_if;
	import dfm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FLOW_BITS-1:0] max_flow;
	logic                 edge_overflow;

	modport source (output valid, max_flow, edge_overflow, input ready);
	modport sink (input valid, max_flow, edge_overflow, output ready);
endinterface

### rtl/core/dfm_ctrl.sv
// Sequencing state machine of the Dinic maximum flow unit.
// Depends on dfm_pkg for the state, command and status types.
module dfm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  dfm_pkg::status_t st,
	output logic             in_ready,
	output dfm_pkg::cmd_t    cmd
);
	import dfm_pkg::*;

	state_t state_q, state_d;

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (st.clr_last) state_d = ST_IDLE;
			ST_IDLE:    if (in_valid) state_d = ST_L_RDA;
			ST_L_RDA:   state_d = st.edge_ok ? ST_L_WRA : ST_L_END;
			ST_L_WRA:   state_d = ST_L_WRB;
			ST_L_WRB:   state_d = ST_L_END;
			ST_L_END:   state_d = st.edge_last ? ST_B_CLR : ST_IDLE;
			ST_B_CLR:   if (st.clr_last) state_d = ST_B_INIT;
			ST_B_INIT:  state_d = ST_B_POP;
			ST_B_POP:   state_d = st.q_empty ? ST_B_DONE : ST_B_U;
			ST_B_U:     state_d = ST_B_U2;
			ST_B_U2:    state_d = ST_B_ARC;
			ST_B_ARC:   state_d = st.k_nil ? ST_B_POP : ST_B_V;
			ST_B_V:     state_d = ST_B_CHK;
			ST_B_CHK:   state_d = ST_B_ARC;
			ST_B_DONE:  state_d = ST_B_DONE2;
			ST_B_DONE2: state_d = st.lvl_zero ? ST_FINISH : ST_D_INIT;
			ST_D_INIT:  state_d = ST_D_LD;
			ST_D_LD:    state_d = ST_D_TOP;
			ST_D_TOP:   state_d = st.at_sink ? ST_D_POP : ST_D_ARC;
			ST_D_ARC:   state_d = st.k_nil ? ST_D_POP : ST_D_V;
			ST_D_V:     state_d = ST_D_CHK;
			ST_D_CHK:   state_d = st.push_ok ? ST_D_LD : ST_D_ARC;
			ST_D_POP:   state_d = st.sp_zero ? ST_B_CLR : ST_D_POPR;
			ST_D_POPR:  state_d = ST_D_UPD1;
			ST_D_UPD1:  state_d = ST_D_UPD2;
			ST_D_UPD2:  state_d = st.flow_zero ? ST_D_POP : ST_D_NXT;
			ST_D_NXT:   state_d = ST_D_TOP;
			ST_FINISH:  if (st.out_free) state_d = ST_CLEAR;
			default:    state_d = ST_CLEAR;
		endcase
	end

	// Command decode.
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.take = (state_q == ST_IDLE) && in_valid;
		unique case (state_q)
			ST_CLEAR:   cmd.op = OP_CLEAR;
			ST_IDLE:    cmd.op = OP_IDLE;
			ST_L_RDA:   cmd.op = OP_L_RDA;
			ST_L_WRA:   cmd.op = OP_L_WRA;
			ST_L_WRB:   cmd.op = OP_L_WRB;
			ST_L_END:   cmd.op = OP_L_END;
			ST_B_CLR:   cmd.op = OP_B_CLR;
			ST_B_INIT:  cmd.op = OP_B_INIT;
			ST_B_POP:   cmd.op = OP_B_POP;
			ST_B_U:     cmd.op = OP_B_U;
			ST_B_U2:    cmd.op = OP_B_U2;
			ST_B_ARC:   cmd.op = OP_B_ARC;
			ST_B_V:     cmd.op = OP_B_V;
			ST_B_CHK:   cmd.op = OP_B_CHK;
			ST_B_DONE:  cmd.op = OP_B_DONE;
			ST_B_DONE2: cmd.op = OP_B_DONE2;
			ST_D_INIT:  cmd.op = OP_D_INIT;
			ST_D_LD:    cmd.op = OP_D_LD;
			ST_D_TOP:   cmd.op = OP_D_TOP;
			ST_D_ARC:   cmd.op = OP_D_ARC;
			ST_D_V:     cmd.op = OP_D_V;
			ST_D_CHK:   cmd.op = OP_D_CHK;
			ST_D_POP:   cmd.op = OP_D_POP;
			ST_D_POPR:  cmd.op = OP_D_POPR;
			ST_D_UPD1:  cmd.op = OP_D_UPD1;
			ST_D_UPD2:  cmd.op = OP_D_UPD2;
			ST_D_NXT:   cmd.op = OP_D_NXT;
			ST_FINISH:  cmd.op = OP_FINISH;
			default:    cmd.op = OP_CLEAR;
		endcase
	end
endmodule

### rtl/core/dfm_datapath.sv
// Graph memories, search registers and result register of the Dinic maximum flow unit.
// Depends on dfm_pkg; driven by commands from dfm_ctrl.
module dfm_datapath #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_ARCS  = 8192,
	parameter int CAP_BITS  = 30
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dfm_pkg::cmd_t                       cmd,
	output dfm_pkg::status_t                    st,
	input  logic [dfm_pkg::NODE_FIELD_BITS-1:0] end_a,
	input  logic [dfm_pkg::NODE_FIELD_BITS-1:0] end_b,
	input  logic [dfm_pkg::CAP_FIELD_BITS-1:0]  capacity,
	input  logic                                last_edge,
	input  logic [dfm_pkg::NODE_FIELD_BITS-1:0] node_count,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [dfm_pkg::FLOW_BITS-1:0]       max_flow,
	output logic                                edge_overflow
);
	import dfm_pkg::*;

	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int AW = $clog2(MAX_ARCS);
	localparam int CW = $clog2(MAX_ARCS + 1);
	localparam int SW = $clog2(MAX_NODES);
	localparam int RW = CAP_BITS + 1;
	localparam int FW = (RW > 30) ? RW : 30;
	localparam logic [AW:0] NIL = {1'b1, {AW{1'b0}}};

	// Memories.
	logic [AW:0]   head_mem [MAX_NODES+1];
	logic [NW-1:0] lvl_mem  [MAX_NODES+1];
	logic [AW:0]   nxt_mem  [MAX_ARCS];
	logic [NW-1:0] tgt_mem  [MAX_ARCS];
	logic [RW-1:0] res_mem  [MAX_ARCS];
	logic [NW-1:0] q_mem    [MAX_NODES];
	logic [NW-1:0] sn_mem   [MAX_NODES];
	logic [AW-1:0] sa_mem   [MAX_NODES];
	logic [FW-1:0] sf_mem   [MAX_NODES];
	logic [FW-1:0] ss_mem   [MAX_NODES];

	// Registered read data.
	logic [AW:0]   head_rd_q, nxt_rd_q;
	logic [NW-1:0] lvl_rd_q, tgt_rd_q, q_rd_q, sn_rd_q;
	logic [RW-1:0] res_rd_q;
	logic [AW-1:0] sa_rd_q;
	logic [FW-1:0] sf_rd_q, ss_rd_q;

	// Control registers.
	logic [CW-1:0]        arc_cnt_q;
	logic                 dropped_q;
	logic [FLOW_BITS-1:0] total_q;
	logic [NW-1:0]        clr_q;
	logic                 out_valid_q;
	logic [SW-1:0]        sp_q;
	logic [NW-1:0]        wr_q, rd_q;

	// Payload registers.
	logic [NW-1:0]        ea_q, eb_q, u_q, v_q, lvu_q;
	logic [RW-1:0]        cap_q, res_q;
	logic                 last_q, edge_ok_q;
	logic [AW:0]          k_q, nxt_q;
	logic [FW-1:0]        flow_q, sent_q, ret_q;
	logic [FLOW_BITS-1:0] flow_out_q;
	logic                 ovf_out_q;

	// Memory port controls.
	logic          head_we, lvl_we, arc_we, res_we, q_we, stk_we;
	logic [NW-1:0] head_wa, head_ra, lvl_wa, lvl_ra;
	logic [AW:0]   head_wd, nxt_wd;
	logic [NW-1:0] lvl_wd, tgt_wd, q_wd;
	logic [AW-1:0] arc_wa, arc_ra, res_wa, res_ra;
	logic [RW-1:0] res_wd;
	logic [SW-1:0] q_wa, q_ra, stk_wa, stk_ra;

	// Derived values.
	logic [NW-1:0]  sink;
	logic           ends_ok, room;
	logic [31:0]    cap32;
	logic [AW-1:0]  k_new, k_pair, k_arc, k_mate;
	logic [FW-1:0]  lim;
	logic [FLOW_BITS:0] sum;
	logic           clr_last;

	// Sink node with the node count clamped into range.
	always_comb begin
		int nc;
		nc = int'(node_count);
		if (nc < 2) nc = 2;
		if (nc > MAX_NODES) nc = MAX_NODES;
		sink = NW'(nc);
	end

	assign ends_ok = (int'(end_a) >= 1) && (int'(end_a) <= MAX_NODES) &&
	                 (int'(end_b) >= 1) && (int'(end_b) <= MAX_NODES);
	assign room    = (int'(arc_cnt_q) + 2) <= MAX_ARCS;
	assign cap32   = 32'(capacity);
	assign k_new   = arc_cnt_q[AW-1:0];
	assign k_pair  = {k_new[AW-1:1], 1'b1};
	assign k_arc   = k_q[AW-1:0];
	assign k_mate  = {k_arc[AW-1:1], ~k_arc[0]};
	assign lim     = (FW'(res_q) < flow_q) ? FW'(res_q) : flow_q;
	assign sum     = {1'b0, total_q} + (FLOW_BITS+1)'(ret_q);
	assign clr_last = (clr_q == NW'(MAX_NODES));

	// Status toward the controller.
	always_comb begin
		st.clr_last  = clr_last;
		st.edge_ok   = edge_ok_q;
		st.edge_last = last_q;
		st.q_empty   = (rd_q == wr_q);
		st.k_nil     = k_q[AW];
		st.bfs_take  = (v_q <= sink) && (lvl_rd_q == '0) && (res_q != '0);
		st.lvl_zero  = (lvl_rd_q == '0);
		st.at_sink   = (u_q == sink);
		st.push_ok   = (res_q != '0) && (v_q <= sink) &&
		               ({1'b0, lvl_rd_q} == ({1'b0, lvu_q} + 1'b1)) &&
		               ((int'(sp_q) + 1) < MAX_NODES);
		st.sp_zero   = (sp_q == '0);
		st.flow_zero = (flow_q == '0);
		st.out_free  = !out_valid_q || out_ready;
	end

	// Memory addresses and write enables for each operation.
	always_comb begin
		head_we = 1'b0; head_wa = clr_q; head_wd = NIL; head_ra = '0;
		lvl_we  = 1'b0; lvl_wa = clr_q; lvl_wd = '0; lvl_ra = '0;
		arc_we  = 1'b0; arc_wa = k_new; nxt_wd = head_rd_q; tgt_wd = eb_q; arc_ra = k_arc;
		res_we  = 1'b0; res_wa = k_new; res_wd = cap_q; res_ra = k_arc;
		q_we    = 1'b0; q_wa = wr_q[SW-1:0]; q_wd = v_q; q_ra = rd_q[SW-1:0];
		stk_we  = 1'b0; stk_wa = sp_q; stk_ra = sp_q - 1'b1;
		unique case (cmd.op)
			OP_CLEAR: begin
				head_we = 1'b1;
				lvl_we  = 1'b1;
			end
			OP_B_CLR: lvl_we = 1'b1;
			OP_L_RDA: head_ra = ea_q;
			OP_L_WRA: begin
				arc_we  = 1'b1;
				res_we  = 1'b1;
				head_we = 1'b1;
				head_wa = ea_q;
				head_wd = {1'b0, k_new};
				head_ra = eb_q;
			end
			OP_L_WRB: begin
				arc_we  = 1'b1;
				arc_wa  = k_pair;
				nxt_wd  = (ea_q == eb_q) ? {1'b0, k_new} : head_rd_q;
				tgt_wd  = ea_q;
				res_we  = 1'b1;
				res_wa  = k_pair;
				head_we = 1'b1;
				head_wa = eb_q;
				head_wd = {1'b0, k_pair};
			end
			OP_B_INIT: begin
				lvl_we = 1'b1;
				lvl_wa = NW'(SOURCE_NODE);
				lvl_wd = NW'(1);
				q_we   = 1'b1;
				q_wa   = '0;
				q_wd   = NW'(SOURCE_NODE);
			end
			OP_B_U: begin
				lvl_ra  = q_rd_q;
				head_ra = q_rd_q;
			end
			OP_B_V, OP_D_V: lvl_ra = tgt_rd_q;
			OP_B_CHK: begin
				lvl_we = st.bfs_take;
				lvl_wa = v_q;
				lvl_wd = lvu_q + 1'b1;
				q_we   = st.bfs_take && (int'(wr_q) < MAX_NODES);
			end
			OP_B_DONE: lvl_ra = sink;
			OP_D_INIT: begin
				head_ra = NW'(SOURCE_NODE);
				lvl_ra  = NW'(SOURCE_NODE);
			end
			OP_D_ARC: begin
				lvl_we = k_q[AW] && (sent_q == '0);
				lvl_wa = u_q;
			end
			OP_D_CHK: begin
				stk_we  = st.push_ok;
				head_ra = v_q;
				lvl_ra  = v_q;
			end
			OP_D_POPR: begin
				res_ra = sa_rd_q;
				lvl_ra = sn_rd_q;
			end
			OP_D_UPD1: begin
				res_we = 1'b1;
				res_wa = k_arc;
				res_wd = res_rd_q - RW'(ret_q);
				res_ra = k_mate;
			end
			OP_D_UPD2: begin
				res_we = 1'b1;
				res_wa = k_mate;
				res_wd = res_rd_q + RW'(ret_q);
			end
			default: ;
		endcase
	end

	// Memory arrays with registered reads.
	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[head_ra];
		if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
		lvl_rd_q <= lvl_mem[lvl_ra];
		if (arc_we) begin
			nxt_mem[arc_wa] <= nxt_wd;
			tgt_mem[arc_wa] <= tgt_wd;
		end
		nxt_rd_q <= nxt_mem[arc_ra];
		tgt_rd_q <= tgt_mem[arc_ra];
		if (res_we) res_mem[res_wa] <= res_wd;
		res_rd_q <= res_mem[res_ra];
		if (q_we) q_mem[q_wa] <= q_wd;
		q_rd_q <= q_mem[q_ra];
		if (stk_we) begin
			sn_mem[stk_wa] <= u_q;
			sa_mem[stk_wa] <= k_arc;
			sf_mem[stk_wa] <= flow_q;
			ss_mem[stk_wa] <= sent_q;
		end
		sn_rd_q <= sn_mem[stk_ra];
		sa_rd_q <= sa_mem[stk_ra];
		sf_rd_q <= sf_mem[stk_ra];
		ss_rd_q <= ss_mem[stk_ra];
	end

	// Control registers: counters, flags, flow total and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_cnt_q   <= '0;
			dropped_q   <= 1'b0;
			total_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			sp_q        <= '0;
			wr_q        <= '0;
			rd_q        <= '0;
		end else begin
			// A new result word is loaded as soon as the output register is free.
			if ((cmd.op == OP_FINISH) && st.out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_CLEAR: begin
					clr_q     <= clr_last ? '0 : clr_q + 1'b1;
					arc_cnt_q <= '0;
					dropped_q <= 1'b0;
					total_q   <= '0;
				end
				OP_B_CLR: clr_q <= clr_last ? '0 : clr_q + 1'b1;
				OP_IDLE: if (cmd.take && ends_ok && !room) dropped_q <= 1'b1;
				OP_L_WRB: arc_cnt_q <= arc_cnt_q + CW'(2);
				OP_B_INIT: begin
					wr_q <= NW'(1);
					rd_q <= '0;
				end
				OP_B_POP: if (rd_q != wr_q) rd_q <= rd_q + 1'b1;
				OP_B_CHK: if (st.bfs_take && (int'(wr_q) < MAX_NODES)) wr_q <= wr_q + 1'b1;
				OP_D_INIT: sp_q <= '0;
				OP_D_CHK: if (st.push_ok) sp_q <= sp_q + 1'b1;
				OP_D_POP: begin
					if (sp_q == '0) begin
						total_q <= sum[FLOW_BITS] ? '1 : sum[FLOW_BITS-1:0];
					end else begin
						sp_q <= sp_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the edge capture and the search.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_IDLE: begin
				if (cmd.take) begin
					ea_q      <= NW'(end_a);
					eb_q      <= NW'(end_b);
					cap_q     <= RW'(cap32[CAP_BITS-1:0]);
					last_q    <= last_edge;
					edge_ok_q <= ends_ok && room;
				end
			end
			OP_B_U: u_q <= q_rd_q;
			OP_B_U2, OP_D_LD: begin
				lvu_q <= lvl_rd_q;
				k_q   <= head_rd_q;
			end
			OP_B_V, OP_D_V: begin
				v_q   <= tgt_rd_q;
				res_q <= res_rd_q;
				nxt_q <= nxt_rd_q;
			end
			OP_B_CHK: k_q <= nxt_q;
			OP_D_INIT: begin
				u_q    <= NW'(SOURCE_NODE);
				flow_q <= FW'(ROOT_LIMIT);
				sent_q <= '0;
			end
			OP_D_TOP: if (u_q == sink) ret_q <= flow_q;
			OP_D_ARC: if (k_q[AW]) ret_q <= sent_q;
			OP_D_CHK: begin
				if (st.push_ok) begin
					u_q    <= v_q;
					flow_q <= lim;
					sent_q <= '0;
				end else begin
					k_q <= nxt_q;
				end
			end
			OP_D_POPR: begin
				u_q    <= sn_rd_q;
				k_q    <= {1'b0, sa_rd_q};
				flow_q <= sf_rd_q;
				sent_q <= ss_rd_q;
			end
			OP_D_UPD1: begin
				lvu_q  <= lvl_rd_q;
				flow_q <= flow_q - ret_q;
				sent_q <= sent_q + ret_q;
			end
			OP_D_UPD2: if (flow_q == '0) ret_q <= sent_q;
			OP_D_NXT: k_q <= nxt_rd_q;
			OP_FINISH: begin
				if (st.out_free) begin
					flow_out_q <= total_q;
					ovf_out_q  <= dropped_q;
				end
			end
			default: ;
		endcase
	end

	// The read of the next arc for the pop path is issued in OP_D_UPD2 through arc_ra = k.
	assign out_valid     = out_valid_q;
	assign max_flow      = flow_out_q;
	assign edge_overflow = ovf_out_q;

`ifndef SYNTH
	// The arc store always holds whole pairs and never overfills.
	a_arc_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(arc_cnt_q[0] == 1'b0) && (int'(arc_cnt_q) <= MAX_ARCS))
		else $error("arc count lost pair alignment or overran the store");

	// Flow handed back up the stack never exceeds the root limit.
	a_ret_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_D_POP) |-> (ret_q <= FW'(ROOT_LIMIT)))
		else $error("returned flow exceeds the root limit");

	// The BFS read pointer never passes the write pointer.
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_B_POP) |-> ((rd_q <= wr_q) && (int'(wr_q) <= MAX_NODES)))
		else $error("BFS queue pointers out of order");
`endif
endmodule

### rtl/core/dinic_max_flow_unit.sv
// After reset and after every result a clearing pass over all MAX_NODES+1 node entries runs.
// Edge words: accept, head read, two arc writes, wrap-up; a dropped word skips the arc writes.
// The word marked last starts the flow run; each phase opens with a level clearing pass over all
// MAX_NODES+1 node levels, then the BFS and DFS walks take data-dependent time.
// One result word per job; it waits in an output register until taken.
// Reset (arst_n, asynchronous, active low) empties the graph and sets node_count to 2.
module dinic_max_flow_unit #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_ARCS  = 8192,
	parameter int CAP_BITS  = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	dfm_edge_if.sink     edges,
	dfm_result_if.source results,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import dfm_pkg::*;

	logic [NODE_FIELD_BITS-1:0] node_count_q;
	cmd_t                       cmd;
	status_t                    st;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_FIELD_BITS'(2);
		end else if (psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT)) begin
			node_count_q <= pwdata[NODE_FIELD_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_q) : 32'd0;

	dfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (edges.valid),
		.st       (st),
		.in_ready (edges.ready),
		.cmd      (cmd)
	);

	dfm_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_ARCS  (MAX_ARCS),
		.CAP_BITS  (CAP_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.end_a         (edges.end_a),
		.end_b         (edges.end_b),
		.capacity      (edges.capacity),
		.last_edge     (edges.last_edge),
		.node_count    (node_count_q),
		.out_ready     (results.ready),
		.out_valid     (results.valid),
		.max_flow      (results.max_flow),
		.edge_overflow (results.edge_overflow)
	);
endmodule
